// ===== rtl/core/dcpi_pkg.sv =====
// dcpi_pkg: shared types, constants and helpers of the DC drive current loop.
// Used by dcpi_ctrl, dcpi_dp and dc_drive_current_pi_loop_unit.
// No dependencies.
package dcpi_pkg;

    localparam int ADC_BITS_DEF   = 12;
    localparam int HIST_DEPTH_DEF = 5;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 22;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 1;

    // calibration: current gain in Q16, voltage gain in Q28 (ADC_BITS shift, then 16)
    localparam longint CUR_GAIN  = 260766;
    localparam longint CUR_BIAS  = 5753163 + 32768;
    localparam longint VOLT_GAIN = 697112199;
    localparam longint VOLT_BIAS = 32768 - 3082394;

    localparam int TRIP_LIMIT  = 5120;
    localparam int DUTY_LIMIT  = 23040;
    localparam int DRIVE_LIMIT = 5760;
    localparam int DUTY_HALF   = 12800;
    localparam longint PI_ROUND = 64'd1 << 27;

    // duty*period / 25600 = ((duty*period) >> 10) / 25
    localparam int CMP_SHIFT = 10;
    localparam int CMP_DIV   = 25;
    localparam int CMP_K     = 21;
    localparam int CMP_RECIP = (1 << CMP_K) / CMP_DIV;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    typedef enum logic [2:0] {
        REG_PWM_PERIOD   = 3'd0,
        REG_DRIVE_MODE   = 3'd1,
        REG_CTRL_ENABLE  = 3'd2,
        REG_SETPOINT     = 3'd3,
        REG_SP_SCALE     = 3'd4,
        REG_PROP_GAIN    = 3'd5,
        REG_LAG_FACTOR   = 3'd6,
        REG_HOLD_GAIN    = 3'd7
    } t_reg;

    localparam logic [1:0] MODE_UNI_PLUS  = 2'd0;
    localparam logic [1:0] MODE_UNI_MINUS = 2'd1;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_CUR, MUL_VOLT, MUL_SP, MUL_LAG, MUL_X, MUL_PE,
        MUL_HD, MUL_CMP, MUL_C25, MUL_CM, MUL_VM
    } t_mul;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CUR, ST_VOLT, ST_SPV, ST_LAG, ST_X, ST_PE, ST_HD,
        ST_ACC, ST_DUTY, ST_CMP, ST_C25, ST_CFIX, ST_CMEAN, ST_VMEAN
    } t_state;

    typedef struct packed {
        t_mul mul_sel;
        logic load;
        logic cur_wr;
        logic volt_wr;
        logic spv_wr;
        logic hist_wr;
        logic e_wr;
        logic acc_init;
        logic acc_add;
        logic pi_wr;
        logic x_wr;
        logic cmp_wr;
        logic cmean_wr;
        logic out_wr;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
        logic signed [15:0] r;
        if (x > SAT_MAX) begin
            r = 16'sh7fff;
        end else if (x < SAT_MIN) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/dc_drive_current_pi_loop_unit.sv =====
// dc_drive_current_pi_loop_unit: top level of the DC drive current loop.
// Depends on dcpi_pkg, dcpi_ctrl and dcpi_dp.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one beat carries the six ADC
//    codes of one PWM period and the run command.
//  - Output channel (o_out_valid / i_out_ready): one beat per input beat with
//    calibrated current and voltage, their moving averages, drive value, duty,
//    both PWM compare values and the run/trip/clamp flags.
//  - Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx in the
//    same cycle; write only while no beat is in flight.
//  - A new beat is taken once the previous one has reached the output
//    register. The steps of a beat run in sequence on the single shared
//    33x22 multiplier.
//  - A result waiting on i_out_ready does not block the next input beat; that
//    beat's sequence holds in its last step until the output register frees.
//  - Synchronous reset loads the register defaults, stops the drive, zeros the
//    histories and sets the duty to fifty percent.
module dc_drive_current_pi_loop_unit #(
    parameter int HISTORY_DEPTH = dcpi_pkg::HIST_DEPTH_DEF,
    parameter int ADC_BITS      = dcpi_pkg::ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ADC_BITS-1:0] i_cur_sample_first,
    input  logic [ADC_BITS-1:0] i_ref_sample_first,
    input  logic [ADC_BITS-1:0] i_volt_sample_first,
    input  logic [ADC_BITS-1:0] i_cur_sample_second,
    input  logic [ADC_BITS-1:0] i_ref_sample_second,
    input  logic [ADC_BITS-1:0] i_volt_sample_second,
    input  logic                i_run_command,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_current_now,
    output logic signed [15:0]  o_current_mean,
    output logic signed [15:0]  o_voltage_now,
    output logic signed [15:0]  o_voltage_mean,
    output logic signed [15:0]  o_drive_voltage,
    output logic [14:0]         o_duty_percent,
    output logic [15:0]         o_compare_first,
    output logic [15:0]         o_compare_second,
    output logic                o_running,
    output logic                o_overcurrent_trip,
    output logic                o_duty_clamped
);

    dcpi_pkg::t_cmd    cmd;
    dcpi_pkg::t_status status;

    dcpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dcpi_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .ADC_BITS      (ADC_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_cur_sample_first   (i_cur_sample_first),
        .i_ref_sample_first   (i_ref_sample_first),
        .i_volt_sample_first  (i_volt_sample_first),
        .i_cur_sample_second  (i_cur_sample_second),
        .i_ref_sample_second  (i_ref_sample_second),
        .i_volt_sample_second (i_volt_sample_second),
        .i_run_command        (i_run_command),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_current_now        (o_current_now),
        .o_current_mean       (o_current_mean),
        .o_voltage_now        (o_voltage_now),
        .o_voltage_mean       (o_voltage_mean),
        .o_drive_voltage      (o_drive_voltage),
        .o_duty_percent       (o_duty_percent),
        .o_compare_first      (o_compare_first),
        .o_compare_second     (o_compare_second),
        .o_running            (o_running),
        .o_overcurrent_trip   (o_overcurrent_trip),
        .o_duty_clamped       (o_duty_clamped)
    );

endmodule

// ===== rtl/core/dcpi_ctrl.sv =====
// dcpi_ctrl: sequencer of the current loop, at most one step of the shared
// multiplier per state. Depends on dcpi_pkg.
module dcpi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dcpi_pkg::t_status i_status,
    output dcpi_pkg::t_cmd   o_cmd
);

    dcpi_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcpi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == dcpi_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = dcpi_pkg::MUL_NONE;
        case (r_state)
            dcpi_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = dcpi_pkg::ST_CUR;
                end
            end
            dcpi_pkg::ST_CUR: begin
                o_cmd.mul_sel = dcpi_pkg::MUL_CUR;
                n_state = dcpi_pkg::ST_VOLT;
            end
            dcpi_pkg::ST_VOLT: begin
                o_cmd.mul_sel = dcpi_pkg::MUL_VOLT;
                o_cmd.cur_wr  = 1'b1;
                n_state = dcpi_pkg::ST_SPV;
            end
            dcpi_pkg::ST_SPV: begin
                o_cmd.mul_sel = dcpi_pkg::MUL_SP;
                o_cmd.volt_wr = 1'b1;
                n_state = dcpi_pkg::ST_LAG;
            end
            dcpi_pkg::ST_LAG: begin
                o_cmd.mul_sel = dcpi_pkg::MUL_LAG;
                o_cmd.spv_wr  = 1'b1;
                o_cmd.hist_wr = 1'b1;
                n_state = dcpi_pkg::ST_X;
            end
            dcpi_pkg::ST_X: begin
                o_cmd.mul_sel = dcpi_pkg::MUL_X;
                o_cmd.e_wr    = 1'b1;
                n_state = dcpi_pkg::ST_PE;
            end
            dcpi_pkg::ST_PE: begin
                o_cmd.mul_sel  = dcpi_pkg::MUL_PE;
                o_cmd.acc_init = 1'b1;
                n_state = dcpi_pkg::ST_HD;
            end
            dcpi_pkg::ST_HD: begin
                o_cmd.mul_sel = dcpi_pkg::MUL_HD;
                o_cmd.acc_add = 1'b1;
                n_state = dcpi_pkg::ST_ACC;
            end
            dcpi_pkg::ST_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state = dcpi_pkg::ST_DUTY;
            end
            dcpi_pkg::ST_DUTY: begin
                o_cmd.pi_wr = 1'b1;
                n_state = dcpi_pkg::ST_CMP;
            end
            dcpi_pkg::ST_CMP: begin
                o_cmd.mul_sel = dcpi_pkg::MUL_CMP;
                n_state = dcpi_pkg::ST_C25;
            end
            dcpi_pkg::ST_C25: begin
                o_cmd.mul_sel = dcpi_pkg::MUL_C25;
                o_cmd.x_wr    = 1'b1;
                n_state = dcpi_pkg::ST_CFIX;
            end
            dcpi_pkg::ST_CFIX: begin
                o_cmd.mul_sel = dcpi_pkg::MUL_CM;
                o_cmd.cmp_wr  = 1'b1;
                n_state = dcpi_pkg::ST_CMEAN;
            end
            dcpi_pkg::ST_CMEAN: begin
                o_cmd.mul_sel  = dcpi_pkg::MUL_VM;
                o_cmd.cmean_wr = 1'b1;
                n_state = dcpi_pkg::ST_VMEAN;
            end
            dcpi_pkg::ST_VMEAN: begin
                // hold here until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.out_wr = 1'b1;
                    n_state = dcpi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dcpi_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/dcpi_dp.sv =====
// dcpi_dp: datapath of the current loop: config registers, shared multiplier,
// calibration, history sums, PI accumulator and output register.
// Depends on dcpi_pkg; driven by dcpi_ctrl.
module dcpi_dp #(
    parameter int HISTORY_DEPTH = dcpi_pkg::HIST_DEPTH_DEF,
    parameter int ADC_BITS      = dcpi_pkg::ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dcpi_pkg::t_cmd      i_cmd,
    output dcpi_pkg::t_status   o_status,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic [ADC_BITS-1:0] i_cur_sample_first,
    input  logic [ADC_BITS-1:0] i_ref_sample_first,
    input  logic [ADC_BITS-1:0] i_volt_sample_first,
    input  logic [ADC_BITS-1:0] i_cur_sample_second,
    input  logic [ADC_BITS-1:0] i_ref_sample_second,
    input  logic [ADC_BITS-1:0] i_volt_sample_second,
    input  logic                i_run_command,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_current_now,
    output logic signed [15:0]  o_current_mean,
    output logic signed [15:0]  o_voltage_now,
    output logic signed [15:0]  o_voltage_mean,
    output logic signed [15:0]  o_drive_voltage,
    output logic [14:0]         o_duty_percent,
    output logic [15:0]         o_compare_first,
    output logic [15:0]         o_compare_second,
    output logic                o_running,
    output logic                o_overcurrent_trip,
    output logic                o_duty_clamped
);

    localparam int DIFF_W     = ADC_BITS + 2;
    localparam int SUM_W      = 16 + $clog2(HISTORY_DEPTH);
    localparam int POS_W      = $clog2(HISTORY_DEPTH);
    localparam int MEAN_RECIP = (1 << SUM_W) / HISTORY_DEPTH;
    localparam int MUL_A_W    = dcpi_pkg::MUL_A_W;
    localparam int MUL_B_W    = dcpi_pkg::MUL_B_W;
    localparam int PROD_W     = dcpi_pkg::PROD_W;
    localparam int ACC_W      = dcpi_pkg::ACC_W;
    localparam int CMP_X_W    = dcpi_pkg::CMP_K;
    localparam int CMP_Q_W    = 17;

    // configuration
    logic [15:0]        r_period;
    logic [1:0]         r_mode;
    logic               r_enable;
    logic signed [15:0] r_setpoint;
    logic signed [3:0]  r_scale;
    logic [15:0]        r_prop;
    logic [15:0]        r_lag;
    logic [15:0]        r_hold;

    // latched sample set
    logic [ADC_BITS-1:0] r_c1, r_r1, r_v1, r_c2, r_r2, r_v2;
    logic                r_cmd;

    // loop state
    logic               r_run;
    logic signed [15:0] r_pe;
    logic signed [15:0] r_pd;
    logic [14:0]        r_duty;
    logic signed [15:0] r_chist [HISTORY_DEPTH];
    logic signed [15:0] r_vhist [HISTORY_DEPTH];
    logic signed [SUM_W-1:0] r_csum, r_vsum;
    logic [POS_W-1:0]   r_pos;

    // working registers
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [15:0] r_cur, r_volt, r_e, r_cmean;
    logic signed [19:0] r_spv;
    logic               r_trip, r_clamp;
    logic [CMP_X_W-1:0] r_x;
    logic [15:0]        r_cmp;
    logic               r_ovalid;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [DIFF_W-1:0]  dc, dv;
    logic signed [DIFF_W:0]    ndv;
    logic [SUM_W-1:0]          abs_c, abs_v;
    logic signed [ACC_W-1:0]   cur_sum, volt_sum, e_diff, u_val, duty_raw;
    logic signed [15:0]        cur_n, volt_n, e_n, vmean_n, cmean_n, pd_n;
    logic                      bipolar, pi_on, clamp_n, run_n, trip_n;
    logic [14:0]               duty_n, duty_start;
    logic [CMP_Q_W-1:0]        cq;
    logic [CMP_X_W:0]          crem;
    logic [15:0]               cmp_n, cf_n, cs_n;

    function automatic logic signed [15:0] mean_fix(input logic [SUM_W-1:0] absx,
                                                    input logic [SUM_W-1:0] q,
                                                    input logic neg);
        logic [SUM_W:0] rem;
        logic [SUM_W:0] qa;
        rem = {1'b0, absx} - ((SUM_W+1)'(q) * (SUM_W+1)'(HISTORY_DEPTH));
        qa  = (SUM_W+1)'(q) + (SUM_W+1)'(rem >= (SUM_W+1)'(HISTORY_DEPTH));
        return neg ? -qa[15:0] : qa[15:0];
    endfunction

    assign bipolar = r_mode[1];

    assign dc = $signed(DIFF_W'(r_c1)) - $signed(DIFF_W'(r_r1))
              + $signed(DIFF_W'(r_c2)) - $signed(DIFF_W'(r_r2));
    assign dv = $signed(DIFF_W'(r_v1)) - $signed(DIFF_W'(r_r1))
              + $signed(DIFF_W'(r_v2)) - $signed(DIFF_W'(r_r2));
    assign ndv = -((DIFF_W+1)'(dv));

    assign abs_c = r_csum[SUM_W-1] ? SUM_W'(-r_csum) : SUM_W'(r_csum);
    assign abs_v = r_vsum[SUM_W-1] ? SUM_W'(-r_vsum) : SUM_W'(r_vsum);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            dcpi_pkg::MUL_CUR: begin
                mul_a = MUL_A_W'(dcpi_pkg::CUR_GAIN);
                mul_b = MUL_B_W'(dc);
            end
            dcpi_pkg::MUL_VOLT: begin
                mul_a = MUL_A_W'(dcpi_pkg::VOLT_GAIN);
                mul_b = MUL_B_W'(ndv);
            end
            dcpi_pkg::MUL_SP: begin
                mul_a = MUL_A_W'(r_setpoint);
                mul_b = MUL_B_W'(r_scale);
            end
            dcpi_pkg::MUL_LAG: begin
                mul_a = MUL_A_W'(r_lag);
                mul_b = MUL_B_W'(r_pe);
            end
            dcpi_pkg::MUL_X: begin
                mul_a = MUL_A_W'($signed(r_prod[31:0]));
                mul_b = MUL_B_W'(r_prop);
            end
            dcpi_pkg::MUL_PE: begin
                mul_a = MUL_A_W'(r_prop);
                mul_b = MUL_B_W'(r_e);
            end
            dcpi_pkg::MUL_HD: begin
                mul_a = MUL_A_W'(r_hold);
                mul_b = MUL_B_W'(r_pd);
            end
            dcpi_pkg::MUL_CMP: begin
                mul_a = MUL_A_W'(r_period);
                mul_b = MUL_B_W'(r_duty);
            end
            dcpi_pkg::MUL_C25: begin
                mul_a = MUL_A_W'(r_prod[dcpi_pkg::CMP_SHIFT+CMP_X_W-1:dcpi_pkg::CMP_SHIFT]);
                mul_b = MUL_B_W'(dcpi_pkg::CMP_RECIP);
            end
            dcpi_pkg::MUL_CM: begin
                mul_a = MUL_A_W'(abs_c);
                mul_b = MUL_B_W'(MEAN_RECIP);
            end
            dcpi_pkg::MUL_VM: begin
                mul_a = MUL_A_W'(abs_v);
                mul_b = MUL_B_W'(MEAN_RECIP);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // calibration
    assign cur_sum  = ACC_W'(r_prod) + ACC_W'(dcpi_pkg::CUR_BIAS);
    assign cur_n    = dcpi_pkg::sat16(cur_sum >>> 16);
    assign volt_sum = (ACC_W'(r_prod) >>> ADC_BITS) + ACC_W'(dcpi_pkg::VOLT_BIAS);
    assign volt_n   = dcpi_pkg::sat16(volt_sum >>> 16);
    assign e_diff   = ACC_W'(r_spv) - ACC_W'(r_cur);
    assign e_n      = dcpi_pkg::sat16(e_diff);

    // run control: stop, start below the trip level, trip above it
    assign duty_start = bipolar ? 15'(dcpi_pkg::DUTY_HALF) : '0;
    always_comb begin
        run_n  = r_run;
        trip_n = 1'b0;
        if (!r_cmd) begin
            run_n = 1'b0;
        end else if (!r_run && (r_cur < 16'(dcpi_pkg::TRIP_LIMIT))) begin
            run_n = 1'b1;
        end
        if (r_cur > 16'(dcpi_pkg::TRIP_LIMIT)) begin
            run_n  = 1'b0;
            trip_n = 1'b1;
        end
    end

    // PI output, duty law and clamp
    assign pi_on = r_enable && r_run;
    assign u_val = r_acc >>> 28;
    assign duty_raw = bipolar ? (u_val <<< 1) + ACC_W'(dcpi_pkg::DUTY_HALF) : (u_val <<< 2);
    always_comb begin
        clamp_n = 1'b0;
        duty_n  = duty_raw[14:0];
        pd_n    = u_val[15:0];
        if (duty_raw > ACC_W'(dcpi_pkg::DUTY_LIMIT)) begin
            clamp_n = 1'b1;
            duty_n  = 15'(dcpi_pkg::DUTY_LIMIT);
            pd_n    = 16'(dcpi_pkg::DRIVE_LIMIT);
        end else if (duty_raw < 0) begin
            clamp_n = 1'b1;
            duty_n  = '0;
            pd_n    = bipolar ? -16'(dcpi_pkg::DRIVE_LIMIT) : '0;
        end
    end

    // compare value: quotient estimate from the reciprocal, then one correction
    assign cq   = r_prod[dcpi_pkg::CMP_K+CMP_Q_W-1:dcpi_pkg::CMP_K];
    assign crem = {1'b0, r_x} - ((CMP_X_W+1)'(cq) * (CMP_X_W+1)'(dcpi_pkg::CMP_DIV));
    assign cmp_n = 16'(cq + CMP_Q_W'(crem >= (CMP_X_W+1)'(dcpi_pkg::CMP_DIV)));

    assign cmean_n = mean_fix(abs_c, r_prod[2*SUM_W-1:SUM_W], r_csum[SUM_W-1]);
    assign vmean_n = mean_fix(abs_v, r_prod[2*SUM_W-1:SUM_W], r_vsum[SUM_W-1]);

    always_comb begin
        case (r_mode)
            dcpi_pkg::MODE_UNI_PLUS: begin
                cf_n = r_cmp;
                cs_n = r_period;
            end
            dcpi_pkg::MODE_UNI_MINUS: begin
                cf_n = r_period;
                cs_n = r_cmp;
            end
            default: begin
                cf_n = r_cmp;
                cs_n = r_cmp;
            end
        endcase
    end

    assign o_status.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= 16'd1250;
            r_mode     <= 2'd2;
            r_enable   <= 1'b0;
            r_setpoint <= '0;
            r_scale    <= 4'sd1;
            r_prop     <= 16'd16243;
            r_lag      <= 16'd16052;
            r_hold     <= 16'd16384;
            r_run      <= 1'b0;
            r_pe       <= '0;
            r_pd       <= '0;
            r_duty     <= 15'(dcpi_pkg::DUTY_HALF);
            r_csum     <= '0;
            r_vsum     <= '0;
            r_pos      <= '0;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_chist[i] <= '0;
                r_vhist[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dcpi_pkg::REG_PWM_PERIOD:  r_period   <= i_cfg_data;
                    dcpi_pkg::REG_DRIVE_MODE:  r_mode     <= i_cfg_data[1:0];
                    dcpi_pkg::REG_CTRL_ENABLE: r_enable   <= i_cfg_data[0];
                    dcpi_pkg::REG_SETPOINT:    r_setpoint <= i_cfg_data;
                    dcpi_pkg::REG_SP_SCALE:    r_scale    <= i_cfg_data[3:0];
                    dcpi_pkg::REG_PROP_GAIN:   r_prop     <= i_cfg_data;
                    dcpi_pkg::REG_LAG_FACTOR:  r_lag      <= i_cfg_data;
                    dcpi_pkg::REG_HOLD_GAIN:   r_hold     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.hist_wr) begin
                r_chist[r_pos] <= r_cur;
                r_vhist[r_pos] <= r_volt;
                r_csum <= r_csum - SUM_W'(r_chist[r_pos]) + SUM_W'(r_cur);
                r_vsum <= r_vsum - SUM_W'(r_vhist[r_pos]) + SUM_W'(r_volt);
                r_pos  <= (r_pos == POS_W'(HISTORY_DEPTH - 1)) ? '0 : r_pos + 1'b1;
                r_run  <= run_n;
                if (r_cmd && !r_run && (r_cur < 16'(dcpi_pkg::TRIP_LIMIT))) begin
                    r_duty <= duty_start;
                end
            end
            if (i_cmd.pi_wr && pi_on) begin
                r_pe   <= r_e;
                r_pd   <= pd_n;
                r_duty <= duty_n;
            end
            if (i_cmd.out_wr) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c1  <= i_cur_sample_first;
            r_r1  <= i_ref_sample_first;
            r_v1  <= i_volt_sample_first;
            r_c2  <= i_cur_sample_second;
            r_r2  <= i_ref_sample_second;
            r_v2  <= i_volt_sample_second;
            r_cmd <= i_run_command;
        end
        if (i_cmd.mul_sel != dcpi_pkg::MUL_NONE) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.cur_wr) begin
            r_cur <= cur_n;
        end
        if (i_cmd.volt_wr) begin
            r_volt <= volt_n;
        end
        if (i_cmd.spv_wr) begin
            r_spv <= r_prod[19:0];
        end
        if (i_cmd.hist_wr) begin
            r_trip <= trip_n;
        end
        if (i_cmd.e_wr) begin
            r_e <= e_n;
        end
        if (i_cmd.acc_init) begin
            r_acc <= ACC_W'(dcpi_pkg::PI_ROUND) - ACC_W'(r_prod);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + (ACC_W'(r_prod) <<< 14);
        end
        if (i_cmd.pi_wr) begin
            r_clamp <= pi_on && clamp_n;
        end
        if (i_cmd.x_wr) begin
            r_x <= r_prod[dcpi_pkg::CMP_SHIFT+CMP_X_W-1:dcpi_pkg::CMP_SHIFT];
        end
        if (i_cmd.cmp_wr) begin
            r_cmp <= cmp_n;
        end
        if (i_cmd.cmean_wr) begin
            r_cmean <= cmean_n;
        end
        if (i_cmd.out_wr) begin
            o_current_now      <= r_cur;
            o_current_mean     <= r_cmean;
            o_voltage_now      <= r_volt;
            o_voltage_mean     <= vmean_n;
            o_drive_voltage    <= r_pd;
            o_duty_percent     <= r_duty;
            o_compare_first    <= cf_n;
            o_compare_second   <= cs_n;
            o_running          <= r_run;
            o_overcurrent_trip <= r_trip;
            o_duty_clamped     <= r_clamp;
        end
    end

endmodule
